>>> hdl/avcbw_pkg.sv
// shared constants and types of the container block walker
// no dependencies
package avcbw_pkg;

  localparam int unsigned OffsetBitsDef = 40;
  localparam int unsigned QueueDepthDef = 2;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 40;
  localparam int unsigned WordW    = 32;
  localparam int unsigned FmtW     = 16;
  localparam int unsigned TrackW   = 8;
  localparam int unsigned CountW   = 33;
  localparam int unsigned ProdW    = WordW + TrackW;

  localparam int unsigned GroupHdrLen = 'h14;
  localparam int unsigned FrameHdrLen = 'h08;
  localparam int unsigned AudioSkip   = 'h08 + 'h04;
  localparam int unsigned AudioHdrLen = 'h04;

  localparam int unsigned DivSteps = WordW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [CfgIdxW-1:0] CfgFileSize    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgTrackCount  = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgTrackSelect = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgHalve       = CfgIdxW'(3);

  typedef struct packed {
    logic audio;
    logic at_end;
  } avcbw_flags_t;

  localparam int unsigned FlagsW = $bits(avcbw_flags_t);

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_MUL,
    BK_OUT
  } avcbw_bk_state_e;

endpackage

>>> hdl/avcbw_if.sv
// valid/ready channel interfaces: block request in, result out, register write
// depends on avcbw_pkg
interface avcbw_in_if import avcbw_pkg::*; #(
  parameter int unsigned OFFSET_BITS = OffsetBitsDef
);
  logic                   valid;
  logic                   ready;
  logic [OFFSET_BITS-1:0] blk_pos;
  logic [WordW-1:0]       type_format_word;
  logic [WordW-1:0]       size_word;
  logic [WordW-1:0]       samples_word;

  modport source (output valid, blk_pos, type_format_word, size_word, samples_word,
                  input ready);
  modport sink (input valid, blk_pos, type_format_word, size_word, samples_word,
                output ready);
endinterface

interface avcbw_out_if import avcbw_pkg::*; #(
  parameter int unsigned OFFSET_BITS = OffsetBitsDef
);
  logic                   valid;
  logic                   ready;
  logic [OFFSET_BITS-1:0] current_offset;
  logic [OFFSET_BITS-1:0] next_offset;
  logic [WordW-1:0]       sample_count;
  logic [OFFSET_BITS-1:0] data_offset;
  logic                   audio_frame;
  logic [FmtW-1:0]        audio_fmt;
  logic                   end_reached;

  modport source (output valid, current_offset, next_offset, sample_count, data_offset,
                  audio_frame, audio_fmt, end_reached, input ready);
  modport sink (input valid, current_offset, next_offset, sample_count, data_offset,
                audio_frame, audio_fmt, end_reached, output ready);
endinterface

interface avcbw_cfg_if import avcbw_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/avcbw_fifo.sv
// small register queue between the front and back parts
// depends on avcbw_pkg
module avcbw_fifo import avcbw_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> hdl/avcbw_front.sv
// front part: takes block requests, tracks the group byte count, classifies
// each block and settles offsets and end of file; depends on avcbw_pkg, avcbw_if
module avcbw_front import avcbw_pkg::*; #(
  parameter int unsigned OFFSET_BITS = OffsetBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  avcbw_in_if.sink               blk_i,
  input  logic [CfgDataW-1:0]    file_size_i,
  input  logic                   halve_i,
  input  logic                   q_full_i,
  output logic                   push_o,
  output logic [OFFSET_BITS-1:0] cur_o,
  output logic [OFFSET_BITS-1:0] nxt_o,
  output logic [OFFSET_BITS-1:0] base_o,
  output logic [WordW-1:0]       samples_o,
  output logic [FmtW-1:0]        fmt_o,
  output logic [WordW-1:0]       abytes_o,
  output avcbw_flags_t           flags_o
);
  localparam int unsigned CmpW = (OFFSET_BITS > CountW) ? OFFSET_BITS : CountW;

  logic [CountW-1:0]      gbl_q, gbl_d;
  logic                   is_hdr, audio, at_end;
  logic [CountW-1:0]      blen;
  logic [CountW:0]        cnt_sub;
  logic [CountW-1:0]      cnt_sat;
  logic [OFFSET_BITS-1:0] fsize, boff;
  logic [CmpW-1:0]        room, nxt_sum;
  logic [WordW-1:0]       smp;

  assign blk_i.ready = !q_full_i;
  assign push_o      = blk_i.valid && !q_full_i;

  assign boff   = blk_i.blk_pos;
  assign fsize  = OFFSET_BITS'(file_size_i);
  assign is_hdr = gbl_q[CountW-1] || (gbl_q == '0);
  assign audio  = !is_hdr && (blk_i.type_format_word[WordW-1:FmtW] == '0);
  assign blen   = is_hdr ? CountW'(GroupHdrLen)
                         : CountW'(FrameHdrLen) + CountW'(blk_i.size_word);

  // count minus block length, saturated at the most negative count
  assign cnt_sub = {gbl_q[CountW-1], gbl_q} - {1'b0, blen};
  assign cnt_sat = (cnt_sub[CountW] && !cnt_sub[CountW-1]) ? {1'b1, {(CountW-1){1'b0}}}
                                                           : cnt_sub[CountW-1:0];

  assign room    = CmpW'(fsize - boff);
  assign at_end  = (boff >= fsize) || (CmpW'(blen) > room);
  assign nxt_sum = CmpW'(boff) + CmpW'(blen);
  assign smp     = halve_i ? (blk_i.samples_word >> 1) : blk_i.samples_word;

  always_comb begin
    gbl_d = gbl_q;
    if (push_o) begin
      if (at_end) begin
        gbl_d = '0;
      end else if (is_hdr) begin
        gbl_d = CountW'(blk_i.size_word);
      end else begin
        gbl_d = cnt_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gbl_q <= '0;
    end else begin
      gbl_q <= gbl_d;
    end
  end

  assign cur_o          = at_end ? fsize : boff;
  assign nxt_o          = at_end ? fsize : nxt_sum[OFFSET_BITS-1:0];
  assign base_o         = boff;
  assign samples_o      = (audio && !at_end) ? smp : '0;
  assign fmt_o          = audio ? blk_i.type_format_word[FmtW-1:0] : '0;
  assign abytes_o       = blk_i.size_word - WordW'(AudioHdrLen);
  assign flags_o.audio  = audio;
  assign flags_o.at_end = at_end;

endmodule

>>> hdl/avcbw_back.sv
// back part: divides the audio bytes among the tracks, scales to the selected
// track and holds the result register; depends on avcbw_pkg, avcbw_if
module avcbw_back import avcbw_pkg::*; #(
  parameter int unsigned OFFSET_BITS = OffsetBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_empty_i,
  output logic                   pop_o,
  input  logic [OFFSET_BITS-1:0] cur_i,
  input  logic [OFFSET_BITS-1:0] nxt_i,
  input  logic [OFFSET_BITS-1:0] base_i,
  input  logic [WordW-1:0]       samples_i,
  input  logic [FmtW-1:0]        fmt_i,
  input  logic [WordW-1:0]       abytes_i,
  input  avcbw_flags_t           flags_i,
  input  logic [TrackW-1:0]      track_count_i,
  input  logic [TrackW-1:0]      track_select_i,
  avcbw_out_if.source            res_o
);
  avcbw_bk_state_e state_q, state_d;

  logic                   skip;
  logic                   out_ld;
  logic                   ov_q, ov_d;
  logic [DivCntW-1:0]     cnt_q, cnt_d;
  logic [OFFSET_BITS-1:0] cur_q, nxt_q, base_q;
  logic [WordW-1:0]       smp_q;
  logic [FmtW-1:0]        fmt_q;
  avcbw_flags_t           flags_q;
  logic [WordW-1:0]       dq_q;
  logic [TrackW-1:0]      rem_q;
  logic [TrackW:0]        trial;
  logic                   ge;
  logic [ProdW-1:0]       prod_q;
  logic [TrackW-1:0]      tsel_m1;

  logic [OFFSET_BITS-1:0] o_cur_q, o_nxt_q, o_doff_q;
  logic [WordW-1:0]       o_smp_q;
  logic [FmtW-1:0]        o_fmt_q;
  avcbw_flags_t           o_flags_q;

  assign skip    = flags_i.audio && (track_count_i > TrackW'(1)) && (track_select_i > TrackW'(1));
  assign trial   = {rem_q, dq_q[WordW-1]};
  assign ge      = trial >= {1'b0, track_count_i};
  assign tsel_m1 = track_select_i - TrackW'(1);

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    out_ld  = 1'b0;
    cnt_d   = cnt_q;
    unique case (state_q)
      BK_IDLE: begin
        cnt_d = '0;
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          state_d = skip ? BK_DIV : BK_OUT;
        end
      end
      BK_DIV: begin
        cnt_d = cnt_q + DivCntW'(1);
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = BK_MUL;
        end
      end
      BK_MUL: begin
        state_d = BK_OUT;
      end
      BK_OUT: begin
        if (!ov_q || res_o.ready) begin
          out_ld  = 1'b1;
          state_d = BK_IDLE;
        end
      end
    endcase
  end

  assign ov_d = out_ld || (ov_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      ov_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      cnt_q   <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q   <= cur_i;
      nxt_q   <= nxt_i;
      base_q  <= base_i;
      smp_q   <= samples_i;
      fmt_q   <= fmt_i;
      flags_q <= flags_i;
      dq_q    <= abytes_i;
      rem_q   <= '0;
      prod_q  <= '0;
    end else if (state_q == BK_DIV) begin
      rem_q <= ge ? TrackW'(trial - {1'b0, track_count_i}) : trial[TrackW-1:0];
      dq_q  <= {dq_q[WordW-2:0], ge};
    end else if (state_q == BK_MUL) begin
      prod_q <= ProdW'(dq_q) * ProdW'(tsel_m1);
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      o_cur_q   <= cur_q;
      o_nxt_q   <= nxt_q;
      o_smp_q   <= smp_q;
      o_fmt_q   <= fmt_q;
      o_flags_q <= flags_q;
      o_doff_q  <= flags_q.audio
                   ? base_q + OFFSET_BITS'(AudioSkip) + OFFSET_BITS'(prod_q) : '0;
    end
  end

  assign res_o.valid          = ov_q;
  assign res_o.current_offset = o_cur_q;
  assign res_o.next_offset    = o_nxt_q;
  assign res_o.sample_count   = o_smp_q;
  assign res_o.data_offset    = o_doff_q;
  assign res_o.audio_frame    = o_flags_q.audio;
  assign res_o.audio_fmt      = o_fmt_q;
  assign res_o.end_reached    = o_flags_q.at_end;

endmodule

>>> hdl/av_container_block_walker_unit.sv
// top level of the container block walker: register file, front, queue, back
// depends on avcbw_pkg, avcbw_if, avcbw_fifo, avcbw_front, avcbw_back
//
// Walks the blocks of a grouped audio/video container, one block request per
// header read. The front part accepts a request in every cycle while the
// queue (QUEUE_DEPTH entries) has room; it keeps the group byte count, so end
// of file and both offsets are settled on acceptance. The back part passes a
// header, video frame or single-track or first-track audio frame straight to
// output; an audio frame for a later track first takes a one-bit-per-cycle
// division of the audio bytes by the track count, then the multiply by the
// track index. Results leave via a registered output stage. Registers must be
// written only while no request is outstanding; the block does not check it.
module av_container_block_walker_unit import avcbw_pkg::*; #(
  parameter int unsigned OFFSET_BITS = OffsetBitsDef,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  avcbw_cfg_if.sink     cfg_i,
  avcbw_in_if.sink      blk_i,
  avcbw_out_if.source   res_o
);
  localparam int unsigned RecW = 3 * OFFSET_BITS + 2 * WordW + FmtW + FlagsW;

  logic [CfgDataW-1:0] file_size_q;
  logic [TrackW-1:0]   track_count_q, track_select_q;
  logic                halve_q;

  logic                   push, pop, q_full, q_empty;
  logic [OFFSET_BITS-1:0] f_cur, f_nxt, f_base, b_cur, b_nxt, b_base;
  logic [WordW-1:0]       f_smp, f_abytes, b_smp, b_abytes;
  logic [FmtW-1:0]        f_fmt, b_fmt;
  avcbw_flags_t           f_flags, b_flags;
  logic [RecW-1:0]        q_wdata, q_rdata;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size_q    <= '0;
      track_count_q  <= TrackW'(1);
      track_select_q <= TrackW'(1);
      halve_q        <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgFileSize:    file_size_q    <= cfg_i.data;
        CfgTrackCount:  track_count_q  <= cfg_i.data[TrackW-1:0];
        CfgTrackSelect: track_select_q <= cfg_i.data[TrackW-1:0];
        CfgHalve:       halve_q        <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  avcbw_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .blk_i       (blk_i),
    .file_size_i (file_size_q),
    .halve_i     (halve_q),
    .q_full_i    (q_full),
    .push_o      (push),
    .cur_o       (f_cur),
    .nxt_o       (f_nxt),
    .base_o      (f_base),
    .samples_o   (f_smp),
    .fmt_o       (f_fmt),
    .abytes_o    (f_abytes),
    .flags_o     (f_flags)
  );

  assign q_wdata = {f_flags, f_fmt, f_smp, f_abytes, f_base, f_nxt, f_cur};
  assign {b_flags, b_fmt, b_smp, b_abytes, b_base, b_nxt, b_cur} = q_rdata;

  avcbw_fifo #(
    .WIDTH (RecW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  avcbw_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .pop_o          (pop),
    .cur_i          (b_cur),
    .nxt_i          (b_nxt),
    .base_i         (b_base),
    .samples_i      (b_smp),
    .fmt_i          (b_fmt),
    .abytes_i       (b_abytes),
    .flags_i        (b_flags),
    .track_count_i  (track_count_q),
    .track_select_i (track_select_q),
    .res_o          (res_o)
  );

`ifndef SYNTHESIS
  a_end_offsets_equal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.end_reached) |-> (res_o.current_offset == res_o.next_offset))
    else $error("end of file result with differing offsets");

  a_end_no_samples : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.end_reached) |-> (res_o.sample_count == '0))
    else $error("end of file result carries samples");

  a_non_audio_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.audio_frame) |->
      ((res_o.data_offset == '0) && (res_o.audio_fmt == '0) && (res_o.sample_count == '0)))
    else $error("non-audio result carries audio fields");

  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !push)
    else $error("queue written while full");
`endif

endmodule
